// ----- hw/rtl/a2b_pkg.sv -----
`default_nettype none
package a2b_pkg;

	localparam int unsigned A2B_QUEUE_DEPTH = 4;

	localparam logic [3:0] REC_HDR_LEN = 4'd10;
	localparam logic [3:0] FRM_HDR_LEN = 4'd5;

	typedef enum logic [1:0] {
		SEC_SPS   = 2'd0,
		SEC_PPS   = 2'd1,
		SEC_FRAME = 2'd2
	} sec_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TRUNC      = 2'd1,
		ST_INCOMPLETE = 2'd2
	} stat_t;

	typedef enum logic [11:0] {
		PH_HDR      = 12'b0000_0000_0001,
		PH_SPS_CNT  = 12'b0000_0000_0010,
		PH_SPS_HI   = 12'b0000_0000_0100,
		PH_SPS_LO   = 12'b0000_0000_1000,
		PH_SPS_PAY  = 12'b0000_0001_0000,
		PH_PPS_CNT  = 12'b0000_0010_0000,
		PH_PPS_HI   = 12'b0000_0100_0000,
		PH_PPS_LO   = 12'b0000_1000_0000,
		PH_PPS_PAY  = 12'b0001_0000_0000,
		PH_REC_DONE = 12'b0010_0000_0000,
		PH_FR_LEN   = 12'b0100_0000_0000,
		PH_FR_PAY   = 12'b1000_0000_0000
	} phase_t;

	// one input word worth of output: optional start code or data byte, then up to two markers
	typedef struct packed {
		logic       start;
		logic       data;
		logic [7:0] dbyte;
		sec_t       sec;
		logic       mk0;
		sec_t       mk0_sec;
		stat_t      mk0_st;
		logic       mk1;
		sec_t       mk1_sec;
		stat_t      mk1_st;
	} desc_t;

endpackage
`default_nettype wire

// ----- hw/rtl/a2b_queue.sv -----
`default_nettype none
module a2b_queue #(
	parameter int unsigned DEPTH = a2b_pkg::A2B_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  a2b_pkg::desc_t push_desc,
	output logic          full,
	input  logic          pop,
	output a2b_pkg::desc_t head,
	output logic          not_empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	a2b_pkg::desc_t   mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CW'(DEPTH)) && !(pop && !not_empty))
		else $error("queue count out of range or pop on empty");

endmodule
`default_nettype wire

// ----- hw/rtl/a2b_front.sv -----
`default_nettype none
module a2b_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           packet_end,
	input  logic           q_full,
	output logic           push,
	output a2b_pkg::desc_t push_desc
);

	logic              awr_q;
	a2b_pkg::phase_t   ph_q;
	logic [3:0]        hp_q;
	logic [4:0]        sets_q;
	logic [31:0]       acc_q;
	logic [31:0]       rem_q;
	logic [1:0]        lbi_q;

	logic              awr_n;
	a2b_pkg::phase_t   ph_n;
	logic [3:0]        hp_n;
	logic [4:0]        sets_n;
	logic [31:0]       acc_n;
	logic [31:0]       rem_n;
	logic [1:0]        lbi_n;

	logic              accept;
	logic [4:0]        sets_dec;
	logic [31:0]       rec_len;
	logic [31:0]       fr_len;
	a2b_pkg::desc_t    d;
	a2b_pkg::stat_t    st;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign sets_dec  = sets_q - 1'b1;
	assign rec_len   = acc_q | {24'b0, in_byte};
	assign fr_len    = {acc_q[23:0], in_byte};
	assign push      = accept && (d.start || d.data || d.mk0);
	assign push_desc = d;

	always_comb begin
		awr_n  = awr_q;
		ph_n   = ph_q;
		hp_n   = hp_q;
		sets_n = sets_q;
		acc_n  = acc_q;
		rem_n  = rem_q;
		lbi_n  = lbi_q;
		st     = a2b_pkg::ST_OK;
		d      = '0;
		d.dbyte = in_byte;
		if (awr_q) begin
			unique case (ph_q) inside
				a2b_pkg::PH_HDR: begin
					if (hp_q >= a2b_pkg::REC_HDR_LEN - 4'd1) begin
						ph_n = a2b_pkg::PH_SPS_CNT;
					end else begin
						hp_n = hp_q + 1'b1;
					end
				end
				a2b_pkg::PH_SPS_CNT: begin
					d.start = 1'b1;
					d.sec   = a2b_pkg::SEC_SPS;
					sets_n  = in_byte[4:0];
					if (in_byte[4:0] == '0) begin
						d.mk0     = 1'b1;
						d.mk0_sec = a2b_pkg::SEC_SPS;
						ph_n      = a2b_pkg::PH_PPS_CNT;
					end else begin
						ph_n = a2b_pkg::PH_SPS_HI;
					end
				end
				a2b_pkg::PH_SPS_HI: begin
					acc_n = {16'b0, in_byte, 8'b0};
					ph_n  = a2b_pkg::PH_SPS_LO;
				end
				a2b_pkg::PH_PPS_HI: begin
					acc_n = {16'b0, in_byte, 8'b0};
					ph_n  = a2b_pkg::PH_PPS_LO;
				end
				a2b_pkg::PH_SPS_LO, a2b_pkg::PH_SPS_PAY: begin
					if (ph_q == a2b_pkg::PH_SPS_LO) begin
						acc_n = rec_len;
						rem_n = rec_len;
					end else begin
						d.data = 1'b1;
						d.sec  = a2b_pkg::SEC_SPS;
						rem_n  = rem_q - 1'b1;
					end
					if (rem_n == '0) begin
						sets_n = sets_dec;
						if (sets_dec == '0) begin
							d.mk0     = 1'b1;
							d.mk0_sec = a2b_pkg::SEC_SPS;
							ph_n      = a2b_pkg::PH_PPS_CNT;
						end else begin
							ph_n = a2b_pkg::PH_SPS_HI;
						end
					end else begin
						ph_n = a2b_pkg::PH_SPS_PAY;
					end
				end
				a2b_pkg::PH_PPS_CNT: begin
					sets_n = in_byte[4:0];
					if (in_byte[4:0] == '0) begin
						d.mk0     = 1'b1;
						d.mk0_sec = a2b_pkg::SEC_PPS;
						ph_n      = a2b_pkg::PH_REC_DONE;
					end else begin
						ph_n = a2b_pkg::PH_PPS_HI;
					end
				end
				a2b_pkg::PH_PPS_LO, a2b_pkg::PH_PPS_PAY: begin
					d.sec = a2b_pkg::SEC_PPS;
					if (ph_q == a2b_pkg::PH_PPS_LO) begin
						acc_n   = rec_len;
						rem_n   = rec_len;
						d.start = 1'b1;
					end else begin
						d.data = 1'b1;
						rem_n  = rem_q - 1'b1;
					end
					if (rem_n == '0) begin
						sets_n = sets_dec;
						if (sets_dec == '0) begin
							d.mk0     = 1'b1;
							d.mk0_sec = a2b_pkg::SEC_PPS;
							ph_n      = a2b_pkg::PH_REC_DONE;
						end else begin
							ph_n = a2b_pkg::PH_PPS_HI;
						end
					end else begin
						ph_n = a2b_pkg::PH_PPS_PAY;
					end
				end
				default: begin
				end
			endcase
			if (packet_end) begin
				if (ph_n == a2b_pkg::PH_HDR || ph_n == a2b_pkg::PH_SPS_CNT ||
				    ph_n == a2b_pkg::PH_SPS_HI || ph_n == a2b_pkg::PH_SPS_LO ||
				    ph_n == a2b_pkg::PH_SPS_PAY) begin
					d.mk0     = 1'b1;
					d.mk0_sec = a2b_pkg::SEC_SPS;
					d.mk0_st  = (ph_n == a2b_pkg::PH_SPS_PAY) ? a2b_pkg::ST_TRUNC
						: a2b_pkg::ST_INCOMPLETE;
					d.mk1     = 1'b1;
					d.mk1_sec = a2b_pkg::SEC_PPS;
					d.mk1_st  = a2b_pkg::ST_INCOMPLETE;
				end else if (ph_n != a2b_pkg::PH_REC_DONE) begin
					st = (ph_n == a2b_pkg::PH_PPS_PAY) ? a2b_pkg::ST_TRUNC
						: a2b_pkg::ST_INCOMPLETE;
					if (d.mk0) begin
						d.mk1     = 1'b1;
						d.mk1_sec = a2b_pkg::SEC_PPS;
						d.mk1_st  = st;
					end else begin
						d.mk0     = 1'b1;
						d.mk0_sec = a2b_pkg::SEC_PPS;
						d.mk0_st  = st;
					end
				end
				awr_n = 1'b0;
			end
		end else begin
			unique case (ph_q)
				a2b_pkg::PH_HDR: begin
					if (hp_q >= a2b_pkg::FRM_HDR_LEN - 4'd1) begin
						ph_n = a2b_pkg::PH_FR_LEN;
					end else begin
						hp_n = hp_q + 1'b1;
					end
				end
				a2b_pkg::PH_FR_LEN: begin
					lbi_n = lbi_q + 1'b1;
					acc_n = fr_len;
					if (lbi_q == 2'd3) begin
						d.start = 1'b1;
						d.sec   = a2b_pkg::SEC_FRAME;
						rem_n   = fr_len;
						acc_n   = '0;
						if (fr_len != '0) begin
							ph_n = a2b_pkg::PH_FR_PAY;
						end
					end
				end
				a2b_pkg::PH_FR_PAY: begin
					d.data = 1'b1;
					d.sec  = a2b_pkg::SEC_FRAME;
					rem_n  = rem_q - 1'b1;
					if (rem_q == 32'd1) begin
						ph_n = a2b_pkg::PH_FR_LEN;
					end
				end
				default: begin
					ph_n = a2b_pkg::PH_HDR;
					hp_n = '0;
				end
			endcase
			if (packet_end) begin
				d.mk0     = 1'b1;
				d.mk0_sec = a2b_pkg::SEC_FRAME;
				d.mk0_st  = (ph_n == a2b_pkg::PH_FR_PAY ||
					(ph_n == a2b_pkg::PH_FR_LEN && lbi_n != '0))
					? a2b_pkg::ST_TRUNC : a2b_pkg::ST_OK;
			end
		end
		if (packet_end) begin
			ph_n   = a2b_pkg::PH_HDR;
			hp_n   = '0;
			sets_n = '0;
			acc_n  = '0;
			rem_n  = '0;
			lbi_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awr_q  <= 1'b1;
			ph_q   <= a2b_pkg::PH_HDR;
			hp_q   <= '0;
			sets_q <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			lbi_q  <= '0;
		end else if (accept) begin
			awr_q  <= awr_n;
			ph_q   <= ph_n;
			hp_q   <= hp_n;
			sets_q <= sets_n;
			acc_q  <= acc_n;
			rem_q  <= rem_n;
			lbi_q  <= lbi_n;
		end
	end

	a_record_once: assert property (@(posedge clk) disable iff (!arst_n)
		!awr_q |=> !awr_q)
		else $error("record mode re-entered");

	a_frame_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!awr_q |-> (ph_q == a2b_pkg::PH_HDR || ph_q == a2b_pkg::PH_FR_LEN ||
			ph_q == a2b_pkg::PH_FR_PAY))
		else $error("record phase seen in frame mode");

endmodule
`default_nettype wire

// ----- hw/rtl/a2b_back.sv -----
`default_nettype none
module a2b_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  a2b_pkg::desc_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic [1:0]     section,
	output logic           section_end,
	output logic [1:0]     status,
	output logic           run_last
);

	a2b_pkg::desc_t  cur_q;
	logic [6:0]      mask_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	a2b_pkg::sec_t   section_q;
	logic            section_end_q;
	a2b_pkg::stat_t  status_q;
	logic            run_last_q;

	logic [6:0]      lowbit;
	logic [6:0]      mask_after;
	logic            out_free;
	logic            emit;
	logic            item_last;
	logic [7:0]      item_byte;
	a2b_pkg::sec_t   item_sec;
	logic            item_end;
	a2b_pkg::stat_t  item_st;

	assign lowbit     = mask_q & (~mask_q + 7'd1);
	assign item_last  = ((mask_q & (mask_q - 7'd1)) == '0);
	assign out_free   = !out_valid_q || out_ready;
	assign emit       = out_free && (mask_q != '0);
	assign mask_after = emit ? (mask_q & ~lowbit) : mask_q;
	assign q_pop      = q_not_empty && (mask_after == '0);

	always_comb begin
		item_byte = '0;
		item_sec  = cur_q.sec;
		item_end  = 1'b0;
		item_st   = a2b_pkg::ST_OK;
		if (lowbit[3]) begin
			item_byte = 8'h01;
		end
		if (lowbit[4]) begin
			item_byte = cur_q.dbyte;
		end
		if (lowbit[5]) begin
			item_sec = cur_q.mk0_sec;
			item_end = 1'b1;
			item_st  = cur_q.mk0_st;
		end
		if (lowbit[6]) begin
			item_sec = cur_q.mk1_sec;
			item_end = 1'b1;
			item_st  = cur_q.mk1_st;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			out_byte_q    <= item_byte;
			section_q     <= item_sec;
			section_end_q <= item_end;
			status_q      <= item_st;
			run_last_q    <= item_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mask_q <= {q_head.mk1, q_head.mk0, q_head.data, {4{q_head.start}}};
			end else begin
				mask_q <= mask_after;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign section     = section_q;
	assign section_end = section_end_q;
	assign status      = status_q;
	assign run_last    = run_last_q;

	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !section_end_q |-> status_q == a2b_pkg::ST_OK)
		else $error("status on a byte word");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && section_end_q |-> out_byte_q == '0)
		else $error("marker word carries a byte");

endmodule
`default_nettype wire

// ----- hw/rtl/avcc_to_annexb_converter_unit.sv -----
`default_nettype none
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_byte, packet_end
// out     | out | out_valid/out_ready | out_byte, section, section_end, status, run_last
//
// One input word per cycle is taken while the descriptor queue has room.
// Each word yields 0 to 6 output words; the expander sends one per cycle unless out_ready stalls it:
// a payload byte alone yields one word, a start code plus markers up to six.
// The QUEUE_DEPTH-entry queue absorbs start-code bursts; input stalls when it fills.
// No clearing pass: in_ready is high from the first cycle after reset.
module avcc_to_annexb_converter_unit #(
	parameter int unsigned QUEUE_DEPTH = a2b_pkg::A2B_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       packet_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] section,
	output logic       section_end,
	output logic [1:0] status,
	output logic       run_last
);

	logic           q_full;
	logic           q_push;
	a2b_pkg::desc_t q_in;
	logic           q_pop;
	a2b_pkg::desc_t q_head;
	logic           q_not_empty;

	a2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.packet_end (packet_end),
		.q_full     (q_full),
		.push       (q_push),
		.push_desc  (q_in)
	);

	a2b_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty)
	);

	a2b_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.section     (section),
		.section_end (section_end),
		.status      (status),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire

// ----- bench/annexb_stream_checker.sv -----
module annexb_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       packet_end,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [1:0] section,
	input  logic       section_end,
	input  logic [1:0] status,
	input  logic       run_last,
	output int         mismatches,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]     b;
		a2b_pkg::sec_t  sec;
		logic           fin;
		a2b_pkg::stat_t st;
		logic           last;
	} annexb_word_t;

	annexb_word_t expected_words[$];
	annexb_word_t burst[$];

	logic            awaiting_record;
	a2b_pkg::phase_t phase;
	logic [3:0]      hdr_pos;
	logic [4:0]      sets_left;
	logic [31:0]     len_acc;
	logic [31:0]     pay_left;
	logic [1:0]      len_idx;
	int              fails = 0;

	assign mismatches = fails;

	function void put(logic [7:0] b, a2b_pkg::sec_t s, logic fin, a2b_pkg::stat_t st);
		annexb_word_t w;
		if (burst.size() < 6) begin
			w.b = b;
			w.sec = s;
			w.fin = fin;
			w.st = st;
			w.last = 1'b0;
			burst.push_back(w);
		end
	endfunction

	function void put_start(a2b_pkg::sec_t s);
		put(8'h00, s, 1'b0, a2b_pkg::ST_OK);
		put(8'h00, s, 1'b0, a2b_pkg::ST_OK);
		put(8'h00, s, 1'b0, a2b_pkg::ST_OK);
		put(8'h01, s, 1'b0, a2b_pkg::ST_OK);
	endfunction

	function void close_sps_set();
		sets_left = sets_left - 5'd1;
		if (sets_left == 5'd0) begin
			put(8'h00, a2b_pkg::SEC_SPS, 1'b1, a2b_pkg::ST_OK);
			phase = a2b_pkg::PH_PPS_CNT;
		end else begin
			phase = a2b_pkg::PH_SPS_HI;
		end
	endfunction

	function void close_pps_set();
		sets_left = sets_left - 5'd1;
		if (sets_left == 5'd0) begin
			put(8'h00, a2b_pkg::SEC_PPS, 1'b1, a2b_pkg::ST_OK);
			phase = a2b_pkg::PH_REC_DONE;
		end else begin
			phase = a2b_pkg::PH_PPS_HI;
		end
	endfunction

	function void reset_parser();
		phase = a2b_pkg::PH_HDR;
		hdr_pos = 4'd0;
		sets_left = 5'd0;
		len_acc = 32'd0;
		pay_left = 32'd0;
		len_idx = 2'd0;
	endfunction

	function void record_byte(logic [7:0] b);
		case (phase)
			a2b_pkg::PH_HDR: begin
				if (hdr_pos >= a2b_pkg::REC_HDR_LEN - 4'd1) phase = a2b_pkg::PH_SPS_CNT;
				else hdr_pos = hdr_pos + 4'd1;
			end
			a2b_pkg::PH_SPS_CNT: begin
				put_start(a2b_pkg::SEC_SPS);
				sets_left = b[4:0];
				if (sets_left == 5'd0) begin
					put(8'h00, a2b_pkg::SEC_SPS, 1'b1, a2b_pkg::ST_OK);
					phase = a2b_pkg::PH_PPS_CNT;
				end else begin
					phase = a2b_pkg::PH_SPS_HI;
				end
			end
			a2b_pkg::PH_SPS_HI: begin
				len_acc = {16'h0000, b, 8'h00};
				phase = a2b_pkg::PH_SPS_LO;
			end
			a2b_pkg::PH_PPS_HI: begin
				len_acc = {16'h0000, b, 8'h00};
				phase = a2b_pkg::PH_PPS_LO;
			end
			a2b_pkg::PH_SPS_LO: begin
				len_acc = len_acc | {24'h000000, b};
				pay_left = len_acc;
				if (pay_left == 32'd0) close_sps_set();
				else phase = a2b_pkg::PH_SPS_PAY;
			end
			a2b_pkg::PH_SPS_PAY: begin
				put(b, a2b_pkg::SEC_SPS, 1'b0, a2b_pkg::ST_OK);
				pay_left = pay_left - 32'd1;
				if (pay_left == 32'd0) close_sps_set();
			end
			a2b_pkg::PH_PPS_CNT: begin
				sets_left = b[4:0];
				if (sets_left == 5'd0) begin
					put(8'h00, a2b_pkg::SEC_PPS, 1'b1, a2b_pkg::ST_OK);
					phase = a2b_pkg::PH_REC_DONE;
				end else begin
					phase = a2b_pkg::PH_PPS_HI;
				end
			end
			a2b_pkg::PH_PPS_LO: begin
				len_acc = len_acc | {24'h000000, b};
				pay_left = len_acc;
				put_start(a2b_pkg::SEC_PPS);
				if (pay_left == 32'd0) close_pps_set();
				else phase = a2b_pkg::PH_PPS_PAY;
			end
			a2b_pkg::PH_PPS_PAY: begin
				put(b, a2b_pkg::SEC_PPS, 1'b0, a2b_pkg::ST_OK);
				pay_left = pay_left - 32'd1;
				if (pay_left == 32'd0) close_pps_set();
			end
			default: ;
		endcase
	endfunction

	function void frame_byte(logic [7:0] b);
		case (phase)
			a2b_pkg::PH_HDR: begin
				if (hdr_pos >= a2b_pkg::FRM_HDR_LEN - 4'd1) phase = a2b_pkg::PH_FR_LEN;
				else hdr_pos = hdr_pos + 4'd1;
			end
			a2b_pkg::PH_FR_LEN: begin
				len_acc = {len_acc[23:0], b};
				len_idx = len_idx + 2'd1;
				if (len_idx == 2'd0) begin
					put_start(a2b_pkg::SEC_FRAME);
					pay_left = len_acc;
					len_acc = 32'd0;
					if (pay_left != 32'd0) phase = a2b_pkg::PH_FR_PAY;
				end
			end
			a2b_pkg::PH_FR_PAY: begin
				put(b, a2b_pkg::SEC_FRAME, 1'b0, a2b_pkg::ST_OK);
				pay_left = pay_left - 32'd1;
				if (pay_left == 32'd0) phase = a2b_pkg::PH_FR_LEN;
			end
			default: begin
				phase = a2b_pkg::PH_HDR;
				hdr_pos = 4'd0;
			end
		endcase
	endfunction

	function void convert_byte(logic [7:0] b, logic fin);
		a2b_pkg::stat_t st;
		burst.delete();
		if (awaiting_record) begin
			record_byte(b);
			if (fin) begin
				if (phase < a2b_pkg::PH_PPS_CNT) begin
					if (phase == a2b_pkg::PH_SPS_PAY) st = a2b_pkg::ST_TRUNC;
					else st = a2b_pkg::ST_INCOMPLETE;
					put(8'h00, a2b_pkg::SEC_SPS, 1'b1, st);
					put(8'h00, a2b_pkg::SEC_PPS, 1'b1, a2b_pkg::ST_INCOMPLETE);
				end else if (phase < a2b_pkg::PH_REC_DONE) begin
					if (phase == a2b_pkg::PH_PPS_PAY) st = a2b_pkg::ST_TRUNC;
					else st = a2b_pkg::ST_INCOMPLETE;
					put(8'h00, a2b_pkg::SEC_PPS, 1'b1, st);
				end
				awaiting_record = 1'b0;
				reset_parser();
			end
		end else begin
			frame_byte(b);
			if (fin) begin
				if (phase == a2b_pkg::PH_FR_PAY ||
					(phase == a2b_pkg::PH_FR_LEN && len_idx != 2'd0)) st = a2b_pkg::ST_TRUNC;
				else st = a2b_pkg::ST_OK;
				put(8'h00, a2b_pkg::SEC_FRAME, 1'b1, st);
				reset_parser();
			end
		end
		if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i]) expected_words.push_back(burst[i]);
	endfunction

	function void check_word();
		annexb_word_t w;
		if (expected_words.size() == 0) begin
			$error("unexpected word: out_byte %0h section %0d section_end %0b status %0d",
				out_byte, section, section_end, status);
			fails++;
		end else begin
			w = expected_words.pop_front();
			if (out_byte !== w.b) begin
				$error("out_byte: expected %0h, actual %0h", w.b, out_byte);
				fails++;
			end
			if (section !== w.sec) begin
				$error("section: expected %0d, actual %0d", w.sec, section);
				fails++;
			end
			if (section_end !== w.fin) begin
				$error("section_end: expected %0b, actual %0b", w.fin, section_end);
				fails++;
			end
			if (status !== w.st) begin
				$error("status: expected %0d, actual %0d", w.st, status);
				fails++;
			end
			if (run_last !== w.last) begin
				$error("run_last: expected %0b, actual %0b", w.last, run_last);
				fails++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_record = 1'b1;
			reset_parser();
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready) convert_byte(in_byte, packet_end);
			if (out_valid && out_ready) check_word();
			outstanding <= expected_words.size();
		end
	end

endmodule

// ----- bench/tb_avcc_to_annexb_converter_unit.sv -----
module tb_avcc_to_annexb_converter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_WORDS = 250;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       packet_end = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [1:0] section;
	logic       section_end;
	logic [1:0] status;
	logic       run_last;
	int         mismatches;
	int         words_due;
	logic       calm = 1'b0;
	int         sent = 0;
	int         quiet = 0;
	logic [7:0] pkt[$];

	avcc_to_annexb_converter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.packet_end (packet_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.section    (section),
		.section_end(section_end),
		.status     (status),
		.run_last   (run_last)
	);

	annexb_stream_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.packet_end (packet_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.section    (section),
		.section_end(section_end),
		.status     (status),
		.run_last   (run_last),
		.mismatches (mismatches),
		.outstanding(words_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 12);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < 12) ? 1 : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		packet_end <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_packet();
		foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
	endtask

	task automatic trim_packet(input int keep);
		while (pkt.size() > keep) pkt.delete(pkt.size() - 1);
	endtask

	task automatic build_record();
		int pick;
		int count;
		logic [15:0] len;
		pkt.delete();
		repeat (10) pkt.push_back(8'($urandom_range(0, 255)));
		for (int s = 0; s < 2; s++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) count = 0;
			else if (pick == 9) count = 31;
			else count = $urandom_range(1, 3);
			pkt.push_back({3'($urandom_range(0, 7)), 5'(count)});
			for (int i = 0; i < count; i++) begin
				pick = $urandom_range(0, 19);
				if (count == 31) len = 16'($urandom_range(0, 1));
				else if (pick < 2) len = 16'd0;
				else if (pick == 2) len = 16'd300;
				else len = 16'($urandom_range(1, 6));
				pkt.push_back(len[15:8]);
				pkt.push_back(len[7:0]);
				repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
			end
		end
		// trailing bytes after a complete record are ignored
		repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 99) < 35) trim_packet($urandom_range(1, pkt.size()));
	endtask

	task automatic build_frame();
		int nalus;
		int pick;
		logic [31:0] len;
		pkt.delete();
		repeat (5) pkt.push_back(8'($urandom_range(0, 255)));
		nalus = $urandom_range(0, 3);
		for (int i = 0; i < nalus; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) len = 32'd0;
			else if (pick < 16) len = $urandom | 32'h0001_0000;
			else len = $urandom_range(1, 12);
			for (int k = 3; k >= 0; k--) pkt.push_back(len[8*k +: 8]);
			if (pick >= 10 && pick < 16) begin
				// length runs past the packet end
				repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom_range(0, 255)));
				break;
			end
			repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 9);
		if (pick == 0) trim_packet($urandom_range(1, 5));
		else if (pick == 1) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
		else if (pick == 2) trim_packet($urandom_range(1, pkt.size()));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_record();
		send_packet();
		// zero-length nalu, then a length running past the packet end
		pkt = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_packet();
		// length prefix cut part-way
		pkt = '{8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_packet();
		// ends inside the header
		pkt = '{8'h27, 8'h01};
		send_packet();
		drain();

		begin
			int stop_at;
			logic paused;
			stop_at = sent + RANDOM_WORDS;
			paused = 1'b0;
			while (sent < stop_at) begin
				calm = (sent >= stop_at - 200) && (sent < stop_at - 120);
				if (!paused && sent >= stop_at - 100) begin
					drain();
					paused = 1'b1;
				end
				build_frame();
				send_packet();
			end
		end
		calm = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && words_due == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/a2b_pkg.sv
hw/rtl/a2b_queue.sv
hw/rtl/a2b_front.sv
hw/rtl/a2b_back.sv
hw/rtl/avcc_to_annexb_converter_unit.sv
bench/annexb_stream_checker.sv
bench/tb_avcc_to_annexb_converter_unit.sv
